// ===== rtl/ptc_pkg.sv =====
// shared types, constants and coefficient tables of the polynomial trig unit
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int INT_FRAC = 30;
  localparam int ARG_SHIFT = INT_FRAC - FRAC_BITS;
  localparam int SQRT_STEPS = 31;
  localparam int HORNER_CELLS = 8;

  localparam logic [63:0] PI_2_Q62 = 64'h6487ED5110B4611A;
  localparam logic signed [32:0] BND_PI2 = 33'(PI_2_Q62 >> (62 - FRAC_BITS));
  localparam logic signed [32:0] BND_PI4 = 33'(PI_2_Q62 >> (63 - FRAC_BITS));
  localparam logic signed [32:0] BND_ONE = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [34:0] PI_2_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef enum logic [2:0] {
    CMD_SIN  = 3'd0,
    CMD_COS  = 3'd1,
    CMD_TAN  = 3'd2,
    CMD_ASIN = 3'd3,
    CMD_ACOS = 3'd4,
    CMD_ATAN = 3'd5
  } cmd_t;

  // word moved along the square root cells
  typedef struct packed {
    logic [2:0]         cmd;
    logic               err;
    logic signed [31:0] x;
    logic [60:0]        rem;
    logic [61:0]        root;
  } sqrt_word_t;

  // word moved along the horner cells
  typedef struct packed {
    logic [2:0]         cmd;
    logic               err;
    logic signed [31:0] x;
    logic signed [32:0] m;
    logic [31:0]        root;
    logic signed [33:0] acc;
  } horner_word_t;

  // coefficient lists padded in front with zeros to nine entries
  localparam logic signed [33:0] SIN_C [9] = '{
    34'sd0, 34'sd0, 34'sd0, -34'sd26, 34'sd2956, -34'sd213040, 34'sd8947847,
    -34'sd178956970, ONE_Q30};
  localparam logic signed [33:0] COS_C [9] = '{
    34'sd0, 34'sd0, 34'sd0, -34'sd280, 34'sd26587, -34'sd1491255, 34'sd44739216,
    -34'sd536870908, ONE_Q30};
  localparam logic signed [33:0] TAN_C [9] = '{
    34'sd0, 34'sd0, 34'sd10218596, 34'sd3114415, 34'sd26376564, 34'sd57309961,
    34'sd143228998, 34'sd357911869, ONE_Q30};
  localparam logic signed [33:0] ARC_C [9] = '{
    34'sd0, 34'sd0, 34'sd0, 34'sd0, 34'sd0, -34'sd20110433, 34'sd79737142,
    -34'sd227756103, 34'sd1686557207};
  localparam logic signed [33:0] ATAN_C [9] = '{
    34'sd3077586, -34'sd17357828, 34'sd46073847, -34'sd80841635, 34'sd114420763,
    -34'sd152566896, 34'sd214679118, -34'sd357911922, ONE_Q30};

  function automatic logic signed [33:0] coef(input logic [2:0] cmd, input logic [3:0] idx);
    logic signed [33:0] c;
    c = '0;
    if (idx <= 4'd8) begin
      unique case (cmd)
        CMD_SIN:  c = SIN_C[idx];
        CMD_COS:  c = COS_C[idx];
        CMD_TAN:  c = TAN_C[idx];
        CMD_ASIN: c = ARC_C[idx];
        CMD_ACOS: c = ARC_C[idx];
        CMD_ATAN: c = ATAN_C[idx];
        default:  c = '0;
      endcase
    end
    return c;
  endfunction

  // q60 product back to q30, round to nearest, ties away from zero
  function automatic logic signed [36:0] qround(input logic signed [67:0] p);
    logic [67:0] mag;
    logic [67:0] q;
    mag = p[67] ? unsigned'(-p) : unsigned'(p);
    q = (mag + (68'd1 << (INT_FRAC - 1))) >> INT_FRAC;
    return p[67] ? -signed'(q[36:0]) : signed'(q[36:0]);
  endfunction

  function automatic logic is_arc(input logic [2:0] cmd);
    return (cmd == CMD_ASIN) || (cmd == CMD_ACOS);
  endfunction

endpackage

// ===== rtl/polynomial_trig_function_unit.sv =====
// top level of the fixed-point sin, cos, tan, asin, acos, atan unit
// depends on ptc_pkg, ptc_sqrt_cell and ptc_horner_cell
`timescale 1ns / 1ps

// in_ channel: one word per function call, command and Q3.28 argument
// out_ channel: one word per call, Q3.28 value and domain flag, in call order
// out-of-domain arguments and unused commands give value zero, flag set
// a new word is taken every cycle while the chain does not hold; from accept
// to out_tvalid a word passes the input register, the 31 cells of the
// digit-serial square root that the arc functions need, the squaring stage,
// 8 horner cells, the final multiply and the output register
// all functions take the same path, so order is kept without tags
// the output has a register plus one skid word; while the receiver stalls
// the skid fills and then the whole chain holds, in_tready drops with it
// (in_tready is a register, no path from out_tready)
// synchronous reset empties the chain, nothing needs clearing
module polynomial_trig_function_unit import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] command, [34:3] argument, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [32] domain_error, rest zero
);

  logic               en;
  logic               take;
  logic [2:0]         in_cmd;
  logic signed [31:0] in_arg;
  logic signed [32:0] arg_ext;
  logic               ok;
  logic signed [32:0] diff;
  sqrt_word_t         front_nxt;

  logic               sq_v [SQRT_STEPS+1];
  sqrt_word_t         sq_w [SQRT_STEPS+1];
  logic               hw_v [HORNER_CELLS+1];
  horner_word_t       hw_w [HORNER_CELLS+1];

  logic [61:0]        root_rnd;
  logic signed [36:0] x2;
  horner_word_t       sq_out_nxt;

  logic signed [33:0] mul_a;
  logic signed [67:0] fin_prod;
  logic signed [36:0] fin_rnd;
  logic signed [34:0] fin_nxt;
  logic               fin_v_r;
  logic signed [34:0] fin_r;
  logic [2:0]         fin_cmd_r;
  logic               fin_err_r;

  logic signed [34:0] res;
  logic [34:0]        res_mag;
  logic [34:0]        res_q;
  logic [31:0]        val;
  logic [32:0]        pipe_word;

  logic               o_v_r;
  logic [32:0]        o_r;
  logic               s_v_r;
  logic [32:0]        s_r;

  assign en = !s_v_r;
  assign in_tready = en;
  assign take = in_tvalid && en;
  assign in_cmd = in_tdata[2:0];
  assign in_arg = signed'(in_tdata[34:3]);
  assign arg_ext = 33'(in_arg);

  // domain check on the raw argument and conversion to q30
  always_comb begin
    unique case (in_cmd)
      CMD_SIN, CMD_COS: ok = (arg_ext >= 0) && (arg_ext <= BND_PI2);
      CMD_TAN:          ok = (arg_ext >= 0) && (arg_ext <= BND_PI4);
      CMD_ASIN, CMD_ACOS: ok = (arg_ext >= 0) && (arg_ext <= BND_ONE);
      CMD_ATAN:         ok = (arg_ext >= -BND_ONE) && (arg_ext <= BND_ONE);
      default:          ok = 1'b0;
    endcase
    front_nxt.cmd = in_cmd;
    front_nxt.err = !ok;
    front_nxt.x = 32'(in_arg <<< ARG_SHIFT);
    diff = 33'(ONE_Q30) - 33'(front_nxt.x);
    if (!ok || !is_arc(in_cmd) || diff < 0) begin
      front_nxt.rem = '0;
    end else begin
      front_nxt.rem = 61'(diff) << INT_FRAC;
    end
    front_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_w[0] <= front_nxt;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    ptc_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .k    (5'(SQRT_STEPS - 1 - j)),
      .v_in (sq_v[j]),
      .w_in (sq_w[j]),
      .v_r  (sq_v[j+1]),
      .w_r  (sq_w[j+1])
    );
  end

  // root rounding (remainder holds n - r*r), squaring and horner seed
  always_comb begin
    root_rnd = (62'(sq_w[SQRT_STEPS].rem) > sq_w[SQRT_STEPS].root) ?
               sq_w[SQRT_STEPS].root + 62'd1 : sq_w[SQRT_STEPS].root;
    x2 = qround(68'(sq_w[SQRT_STEPS].x * sq_w[SQRT_STEPS].x));
    sq_out_nxt.cmd = sq_w[SQRT_STEPS].cmd;
    sq_out_nxt.err = sq_w[SQRT_STEPS].err;
    sq_out_nxt.x = sq_w[SQRT_STEPS].x;
    sq_out_nxt.m = is_arc(sq_w[SQRT_STEPS].cmd) ? 33'(sq_w[SQRT_STEPS].x) : x2[32:0];
    sq_out_nxt.root = root_rnd[31:0];
    sq_out_nxt.acc = coef(sq_w[SQRT_STEPS].cmd, 4'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_v[0] <= 1'b0;
    end else if (en) begin
      hw_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hw_w[0] <= sq_out_nxt;
    end
  end

  for (genvar j = 0; j < HORNER_CELLS; j++) begin : g_horner
    ptc_horner_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .idx  (4'(j + 1)),
      .v_in (hw_v[j]),
      .w_in (hw_w[j]),
      .v_r  (hw_v[j+1]),
      .w_r  (hw_w[j+1])
    );
  end

  // odd functions times x, arc functions times the root, cos as is
  always_comb begin
    mul_a = is_arc(hw_w[HORNER_CELLS].cmd) ? signed'({2'b00, hw_w[HORNER_CELLS].root}) :
            34'(hw_w[HORNER_CELLS].x);
    fin_prod = 68'(mul_a * hw_w[HORNER_CELLS].acc);
    fin_rnd = qround(fin_prod);
    if (hw_w[HORNER_CELLS].cmd == CMD_COS) begin
      fin_nxt = 35'(hw_w[HORNER_CELLS].acc);
    end else begin
      fin_nxt = fin_rnd[34:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= hw_v[HORNER_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
      fin_cmd_r <= hw_w[HORNER_CELLS].cmd;
      fin_err_r <= hw_w[HORNER_CELLS].err;
    end
  end

  // asin correction and q30 to output format with rounding
  always_comb begin
    res = (fin_cmd_r == CMD_ASIN) ? PI_2_Q30 - fin_r : fin_r;
    res_mag = res[34] ? unsigned'(-res) : unsigned'(res);
    res_q = (res_mag + (35'd1 << (ARG_SHIFT - 1))) >> ARG_SHIFT;
    val = res[34] ? 32'(-res_q) : res_q[31:0];
    pipe_word = fin_err_r ? {1'b1, 32'd0} : {1'b0, val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (s_v_r) begin
      if (out_tready) begin
        o_v_r <= 1'b1;
        s_v_r <= 1'b0;
      end
    end else if (!o_v_r || out_tready) begin
      o_v_r <= fin_v_r;
    end else if (fin_v_r) begin
      s_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v_r) begin
      if (out_tready) begin
        o_r <= s_r;
      end
    end else if (!o_v_r || out_tready) begin
      o_r <= pipe_word;
    end else begin
      s_r <= pipe_word;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata = {7'd0, o_r};

endmodule

// ===== rtl/ptc_sqrt_cell.sv =====
// one digit step of the pipelined square root of the arc functions
// depends on ptc_pkg
`timescale 1ns / 1ps

module ptc_sqrt_cell import ptc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [4:0] k,
  input  logic       v_in,
  input  sqrt_word_t w_in,
  output logic       v_r,
  output sqrt_word_t w_r
);

  logic [61:0] bit_val;
  logic [61:0] trial;
  sqrt_word_t  w_nxt;

  always_comb begin
    bit_val = 62'd1 << {k, 1'b0};
    trial = w_in.root + bit_val;
    w_nxt = w_in;
    if ({1'b0, w_in.rem} >= trial) begin
      w_nxt.rem = w_in.rem - trial[60:0];
      w_nxt.root = (w_in.root >> 1) + bit_val;
    end else begin
      w_nxt.root = w_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

endmodule

// ===== rtl/ptc_horner_cell.sv =====
// one horner step: acc times operand, rounded, plus this cell's coefficient
// depends on ptc_pkg
`timescale 1ns / 1ps

module ptc_horner_cell import ptc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [3:0]   idx,
  input  logic         v_in,
  input  horner_word_t w_in,
  output logic         v_r,
  output horner_word_t w_r
);

  logic signed [67:0] prod;
  logic signed [36:0] sum;
  horner_word_t       w_nxt;

  always_comb begin
    prod = 68'(w_in.acc * w_in.m);
    sum = qround(prod) + 37'(coef(w_in.cmd, idx));
    w_nxt = w_in;
    w_nxt.acc = sum[33:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

endmodule
